// ----- design/vrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// Holds the stream widths, result kinds, arithmetic opcodes and the
// request and response structs of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int unsigned COORD_BITS_DEF    = 16;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Working width of the shared unit: sum of squares and scaled dividends.
  localparam int unsigned ARITH_W    = 64;
  localparam int unsigned IN_DATA_W  = 224;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  function automatic logic [31:0] sat32(input logic [ARITH_W-1:0] v);
    sat32 = (|v[ARITH_W-1:32]) ? SAT32 : v[31:0];
  endfunction

endpackage

// ----- design/vrt_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_arith: shared multiply, divide and square root unit
// Registers products directly; divides one quotient bit per cycle and takes
// square roots one result bit per cycle over a single compare-subtract.
// ----------------------------------------------------------------------------
module vrt_arith (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vrt_pkg::arith_req_t          req_i,
  input  logic [vrt_pkg::ARITH_W-1:0]  a_i,
  input  logic [31:0]                  b_i,
  output vrt_pkg::arith_rsp_t          rsp_o,
  output logic [vrt_pkg::ARITH_W-1:0]  res_o
);
  import vrt_pkg::*;

  logic [ARITH_W-1:0] acc_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;
  logic [31:0]        b_q;
  arith_op_e          op_q;
  logic [6:0]         cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [64:0] mprod;
  logic [33:0] remsh;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  assign mprod = a_i[32:0] * b_i;

  always_comb begin
    if (op_q == OP_SQRT) begin
      remsh = {rem_q[31:0], acc_q[ARITH_W-1 -: 2]};
      trial = {root_q, 2'b01};
    end else begin
      remsh = {rem_q[32:0], acc_q[ARITH_W-1]};
      trial = {2'b00, b_q};
    end
    ge   = (remsh >= trial);
    diff = remsh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q <= req_i.op;
        b_q  <= b_i;
        rem_q  <= '0;
        root_q <= '0;
        unique case (req_i.op)
          OP_MUL: begin
            acc_q  <= mprod[ARITH_W-1:0];
            done_q <= 1'b1;
          end
          OP_DIV: begin
            acc_q  <= a_i;
            cnt_q  <= 7'(ARITH_W);
            busy_q <= 1'b1;
          end
          OP_SQRT: begin
            acc_q  <= a_i;
            cnt_q  <= 7'(ARITH_W / 2);
            busy_q <= 1'b1;
          end
          default: done_q <= 1'b1;
        endcase
      end else if (busy_q) begin
        rem_q <= ge ? diff : remsh;
        if (op_q == OP_SQRT) begin
          acc_q  <= {acc_q[ARITH_W-3:0], 2'b00};
          root_q <= {root_q[30:0], ge};
        end else begin
          acc_q <= {acc_q[ARITH_W-2:0], ge};
        end
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o      = (op_q == OP_SQRT) ? {{(ARITH_W-32){1'b0}}, root_q} : acc_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

// ----- design/voxel_ray_traversal_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top: Amanatides-Woo voxel walk in fixed point
// Sets up a ray on a start transfer, then answers voxel queries one by one.
// ----------------------------------------------------------------------------
// A start transfer (tuser 0) sets up the ray on one shared arithmetic unit:
// three squarings, a 32-step square root, and per moving axis two 64-step
// divisions and one multiply. When setup ends, the first voxel query leaves
// once the output register is free. The divider, at one quotient bit per
// cycle, dominates the setup. An answer transfer (tuser 1) is handled
// combinationally and its result goes to an output register, so a new
// transfer is taken as soon as that register is free or being emptied.
module voxel_ray_traversal_top #(
  parameter int unsigned COORD_BITS    = vrt_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = vrt_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
  // max_distance, can_traverse, is_solid
  input  logic [vrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // voxel_x, voxel_y, voxel_z, normal_x, normal_y, normal_z, hit_distance
  output logic [vrt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind
  output logic [1:0]                      m_axis_tuser
);
  import vrt_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned FB = FRACTION_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SUMSQ = 7'b0000010,
    S_ROOT  = 7'b0000100,
    S_AXIS  = 7'b0001000,
    S_INC   = 7'b0010000,
    S_GAP   = 7'b0100000,
    S_NEXT  = 7'b1000000
  } state_e;

  state_e state_q;
  logic   issued_q;
  logic   pend_out_q;

  logic          active_q;
  logic [CB-1:0] cell_q [3];
  logic [1:0]    sign_q [3];
  logic [31:0]   nc_q   [3];
  logic [31:0]   inc_q  [3];
  logic [1:0]    face_q [3];
  logic [31:0]   dist_q;
  logic [23:0]   lim_q;

  logic [31:0]        mag_q  [3];
  logic               neg_q  [3];
  logic [FB-1:0]      frac_q [3];
  logic [ARITH_W-1:0] sum_q;
  logic [31:0]        len_q;
  logic [ARITH_W-1:0] prod_q;
  logic [1:0]         axis_q;

  logic                  m_valid_q;
  logic [1:0]            m_kind_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  arith_req_t         req;
  arith_rsp_t         rsp;
  logic [ARITH_W-1:0] a_op;
  logic [31:0]        b_op;
  logic [ARITH_W-1:0] res;

  vrt_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (a_op),
    .b_i    (b_op),
    .rsp_o  (rsp),
    .res_o  (res)
  );

  function automatic logic [OUT_DATA_W-1:0] pack_out(
    input logic [CB-1:0] cx, input logic [CB-1:0] cy, input logic [CB-1:0] cz,
    input logic [5:0] nrm, input logic [23:0] hdist);
    pack_out = {2'b00, hdist, nrm, 16'($signed(cz)), 16'($signed(cy)),
                16'($signed(cx))};
  endfunction

  // Input fields.
  logic [31:0] in_org [3];
  logic [31:0] in_dir [3];
  logic [23:0] in_maxd;
  logic        in_can;
  logic        in_solid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_org[i] = s_axis_tdata[32*i +: 32];
      in_dir[i] = s_axis_tdata[96 + 32*i +: 32];
    end
    in_maxd  = s_axis_tdata[215:192];
    in_can   = s_axis_tdata[216];
    in_solid = s_axis_tdata[217];
  end

  logic slot_free;
  logic in_fire;
  logic start_miss;
  logic out_load;
  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !pend_out_q && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign start_miss    = (in_dir[0] == '0 && in_dir[1] == '0 && in_dir[2] == '0) ||
                         (in_maxd == '0);
  // The output register is loaded with a new result in this cycle.
  assign out_load      = (pend_out_q && slot_free) ||
                         (in_fire && (s_axis_tuser[0] || start_miss));

  // Step decision on an answer transfer.
  logic [1:0]    sel;
  logic [1:0]    s_sel;
  logic [32:0]   nc_sum;
  logic [CB-1:0] cell_nx [3];
  always_comb begin
    if (nc_q[0] < nc_q[1]) sel = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
    else                   sel = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
    s_sel  = sign_q[sel];
    nc_sum = {1'b0, nc_q[sel]} + {1'b0, inc_q[sel]};
    for (int i = 0; i < 3; i++) begin
      cell_nx[i] = cell_q[i];
      if (2'(i) == sel) begin
        if (s_sel == 2'b01)      cell_nx[i] = cell_q[i] + CB'(1);
        else if (s_sel == 2'b11) cell_nx[i] = cell_q[i] - CB'(1);
      end
    end
  end

  // Gap to the first boundary on the current setup axis.
  logic [FB:0] gap;
  assign gap = neg_q[axis_q] ? {1'b0, frac_q[axis_q]}
                             : ((FB+1)'(1) << FB) - {1'b0, frac_q[axis_q]};

  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    a_op      = '0;
    b_op      = mag_q[axis_q];
    unique case (state_q)
      S_SUMSQ: begin
        req.op = OP_MUL;
        a_op   = ARITH_W'(mag_q[axis_q]);
      end
      S_ROOT: begin
        req.op = OP_SQRT;
        a_op   = sum_q;
      end
      S_INC: begin
        req.op = OP_DIV;
        a_op   = ARITH_W'(len_q) << FB;
      end
      S_GAP: begin
        req.op = OP_MUL;
        a_op   = ARITH_W'(gap);
        b_op   = len_q;
      end
      S_NEXT: begin
        req.op = OP_DIV;
        a_op   = prod_q;
      end
      default: ;
    endcase
    if ((state_q == S_SUMSQ) || (state_q == S_ROOT) || (state_q == S_INC) ||
        (state_q == S_GAP) || (state_q == S_NEXT)) begin
      req.start = !issued_q && !rsp.busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      issued_q   <= 1'b0;
      pend_out_q <= 1'b0;
      active_q   <= 1'b0;
      m_valid_q  <= 1'b0;
      m_kind_q   <= KIND_MISS;
      axis_q     <= 2'd0;
      dist_q     <= '0;
      lim_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        cell_q[i] <= '0;
        sign_q[i] <= '0;
        nc_q[i]   <= '0;
        inc_q[i]  <= '0;
        face_q[i] <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) m_valid_q <= 1'b0;
      if (req.start)     issued_q <= 1'b1;
      else if (rsp.done) issued_q <= 1'b0;

      // The first query of a ray leaves once the output register is free.
      if (pend_out_q && slot_free) begin
        pend_out_q <= 1'b0;
        m_valid_q  <= 1'b1;
        m_kind_q   <= KIND_QUERY;
        m_data_q   <= pack_out(cell_q[0], cell_q[1], cell_q[2], 6'd0, 24'd0);
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (s_axis_tuser[0] == 1'b0)) begin
            if (start_miss) begin
              active_q  <= 1'b0;
              m_valid_q <= 1'b1;
              m_kind_q  <= KIND_MISS;
              m_data_q  <= '0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                neg_q[i]  <= in_dir[i][31];
                mag_q[i]  <= in_dir[i][31] ? (32'd0 - in_dir[i]) : in_dir[i];
                frac_q[i] <= in_org[i][FB-1:0];
                cell_q[i] <= CB'($signed(in_org[i]) >>> FB);
                sign_q[i] <= (in_dir[i] == '0) ? 2'b00
                           : (in_dir[i][31] ? 2'b11 : 2'b01);
                face_q[i] <= 2'b00;
              end
              dist_q   <= '0;
              lim_q    <= in_maxd;
              active_q <= 1'b1;
              sum_q    <= '0;
              axis_q   <= 2'd0;
              state_q  <= S_SUMSQ;
            end
          end else if (in_fire) begin
            m_valid_q <= 1'b1;
            if (!active_q || !in_can) begin
              active_q <= 1'b0;
              m_kind_q <= KIND_MISS;
              m_data_q <= '0;
            end else if (in_solid) begin
              active_q <= 1'b0;
              m_kind_q <= KIND_HIT;
              m_data_q <= pack_out(cell_q[0], cell_q[1], cell_q[2],
                                   {face_q[2], face_q[1], face_q[0]}, dist_q[23:0]);
            end else begin
              for (int i = 0; i < 3; i++) begin
                cell_q[i] <= cell_nx[i];
                face_q[i] <= (2'(i) == sel) ? (2'b00 - s_sel) : 2'b00;
              end
              dist_q    <= nc_q[sel];
              nc_q[sel] <= nc_sum[32] ? SAT32 : nc_sum[31:0];
              if (nc_q[sel] > {8'd0, lim_q}) begin
                active_q <= 1'b0;
                m_kind_q <= KIND_MISS;
                m_data_q <= '0;
              end else begin
                m_kind_q <= KIND_QUERY;
                m_data_q <= pack_out(cell_nx[0], cell_nx[1], cell_nx[2], 6'd0, 24'd0);
              end
            end
          end
        end
        S_SUMSQ: begin
          if (rsp.done) begin
            sum_q <= sum_q + res;
            if (axis_q == 2'd2) begin
              axis_q  <= 2'd0;
              state_q <= S_ROOT;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        S_ROOT: begin
          if (rsp.done) begin
            len_q   <= res[31:0];
            state_q <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (mag_q[axis_q] == '0) begin
            inc_q[axis_q] <= SAT32;
            nc_q[axis_q]  <= SAT32;
            if (axis_q == 2'd2) begin
              pend_out_q <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            state_q <= S_INC;
          end
        end
        S_INC: begin
          if (rsp.done) begin
            inc_q[axis_q] <= sat32(res);
            state_q       <= S_GAP;
          end
        end
        S_GAP: begin
          if (rsp.done) begin
            prod_q  <= res;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (rsp.done) begin
            nc_q[axis_q] <= sat32(res);
            if (axis_q == 2'd2) begin
              pend_out_q <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_AXIS;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- design/vrt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_checker: port-level checks of the voxel ray traversal block
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
module vrt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [vrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);
  import vrt_pkg::*;

  // A stalled result transfer keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == KIND_QUERY || m_axis_tuser == KIND_HIT ||
       m_axis_tuser == KIND_MISS))
    else $error("undefined result kind");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_MISS |-> m_axis_tdata == '0)
    else $error("miss carries a payload");

  a_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_QUERY |-> m_axis_tdata[77:48] == '0)
    else $error("query carries a normal or distance");

  // At most one axis of a hit normal is set.
  a_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $countones({|m_axis_tdata[49:48], |m_axis_tdata[51:50],
                  |m_axis_tdata[53:52]}) <= 1)
    else $error("normal on more than one axis");

endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
